// ===== rtl/tractor_trailer_propagate_macros.svh =====
// assertion macros for the pose propagator checker
`ifndef TRACTOR_TRAILER_PROPAGATE_MACROS_SVH
`define TRACTOR_TRAILER_PROPAGATE_MACROS_SVH

// consequent checked in the same cycle
`define TTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ttp_pkg.sv =====
`timescale 1ns / 1ps
package ttp_pkg;

    localparam int unsigned MAX_STEPS   = 1023;
    localparam bit          STEER_CLAMP = 1'b1;

    localparam logic signed [20:0] TAN_LIM     = 21'sd1048575;
    localparam logic signed [31:0] RAD_TO_TURN = 32'sd683565276;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [3:0] CORDIC_LAST = 4'd15;
    localparam logic [4:0] DIV_LAST    = 5'd28;

    localparam logic [15:0]        RST_STEP_SIZE  = 16'd656;
    localparam logic [23:0]        RST_INV_WB     = 24'd21845;
    localparam logic [23:0]        RST_INV_TL     = 24'd13107;
    localparam logic signed [24:0] RST_HITCH_GAIN = 25'sd4369;
    localparam logic signed [15:0] RST_STEER_MIN  = -16'sd9830;
    localparam logic signed [15:0] RST_STEER_MAX  = 16'sd9830;
    localparam logic signed [15:0] RST_HITCH_MIN  = -16'sd24576;
    localparam logic signed [15:0] RST_HITCH_MAX  = 16'sd24576;

    typedef enum logic [2:0] {
        REG_STEP_SIZE  = 3'd0,
        REG_INV_WB     = 3'd1,
        REG_INV_TL     = 3'd2,
        REG_HITCH_GAIN = 3'd3,
        REG_STEER_MIN  = 3'd4,
        REG_STEER_MAX  = 3'd5,
        REG_HITCH_MIN  = 3'd6,
        REG_HITCH_MAX  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic              done;
        logic signed [15:0] cos_q;
        logic signed [15:0] sin_q;
    } t_trig;

    function automatic logic [31:0] atan_turn(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'd536870912;
            4'd1:    v = 32'd316933406;
            4'd2:    v = 32'd167458907;
            4'd3:    v = 32'd85004756;
            4'd4:    v = 32'd42667331;
            4'd5:    v = 32'd21354465;
            4'd6:    v = 32'd10679838;
            4'd7:    v = 32'd5340245;
            4'd8:    v = 32'd2670163;
            4'd9:    v = 32'd1335087;
            4'd10:   v = 32'd667544;
            4'd11:   v = 32'd333772;
            4'd12:   v = 32'd166886;
            4'd13:   v = 32'd83443;
            4'd14:   v = 32'd41722;
            4'd15:   v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ttp_cordic.sv =====
`timescale 1ns / 1ps
module ttp_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [31:0]   i_turn,
    output ttp_pkg::t_trig o_trig
);

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [32:0] r_a;
    logic [3:0]         r_i;
    logic               r_flip;
    logic               r_run;
    logic               r_fin;
    ttp_pkg::t_trig     r_trig;

    logic signed [32:0] a_in;
    logic signed [32:0] a_fold;
    logic               fold_flip;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] at;

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [34:0] sh;
        logic signed [15:0] res;
        t  = $signed({v[33], v}) + 35'sd32768;
        sh = t >>> 16;
        if (sh > 35'sd16384) begin
            res = 16'sd16384;
        end else if (sh < -35'sd16384) begin
            res = -16'sd16384;
        end else begin
            res = sh[15:0];
        end
        return res;
    endfunction

    // fold the angle into the half turn around zero
    always_comb begin
        a_in = $signed({i_turn[31], i_turn});
        fold_flip = 1'b0;
        a_fold = a_in;
        if (a_in > 33'sd1073741824) begin
            a_fold = a_in - 33'sd2147483648;
            fold_flip = 1'b1;
        end else if (a_in < -33'sd1073741824) begin
            a_fold = a_in + 33'sd2147483648;
            fold_flip = 1'b1;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = $signed({1'b0, ttp_pkg::atan_turn(r_i)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_trig <= '0;
        end else begin
            r_trig.done <= 1'b0;
            if (i_go) begin
                r_x    <= ttp_pkg::CORDIC_GAIN;
                r_y    <= 34'sd0;
                r_a    <= a_fold;
                r_flip <= fold_flip;
                r_i    <= 4'd0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                if (r_a >= 33'sd0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_a <= r_a - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_a <= r_a + at;
                end
                if (r_i == ttp_pkg::CORDIC_LAST) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end else begin
                    r_i <= r_i + 4'd1;
                end
            end
            if (r_fin) begin
                r_fin       <= 1'b0;
                r_trig.done <= 1'b1;
                if (r_flip) begin
                    r_trig.cos_q <= -to_q14(r_x);
                    r_trig.sin_q <= -to_q14(r_y);
                end else begin
                    r_trig.cos_q <= to_q14(r_x);
                    r_trig.sin_q <= to_q14(r_y);
                end
            end
        end
    end

    assign o_trig = r_trig;

endmodule

// ===== rtl/ttp_mul.sv =====
`timescale 1ns / 1ps
module ttp_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic signed [63:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_a;
    logic signed [31:0] r_b;
    logic signed [63:0] r_acc;
    logic               r_lo;
    logic               r_hi;
    logic               r_done;

    logic signed [64:0] lo_p;
    logic signed [63:0] hi_p;

    // low digit unsigned, high digit signed
    assign lo_p = $signed({1'b0, r_a[31:0]}) * r_b;
    assign hi_p = $signed(r_a[63:32]) * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo   <= 1'b0;
            r_hi   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_a  <= i_a;
                r_b  <= i_b;
                r_lo <= 1'b1;
            end
            if (r_lo) begin
                r_acc <= lo_p[63:0];
                r_lo  <= 1'b0;
                r_hi  <= 1'b1;
            end
            if (r_hi) begin
                r_acc  <= r_acc + $signed({hi_p[31:0], 32'd0});
                r_hi   <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/tractor_trailer_propagate.sv =====
`timescale 1ns / 1ps
// a tan whose cosine is zero skips the divider
// a new start is taken only when idle, busy stays high until the result strobe
// per tick cost set by the shared multiplier, the 16-step cordic and
// the 29-step divider for tan
// reset: synchronous active low, control and config registers return to their reset values, block idle
module tractor_trailer_propagate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [15:0] i_start_heading,
    input  logic signed [15:0] i_start_steer,
    input  logic signed [15:0] i_start_hitch,
    input  logic signed [15:0] i_speed,
    input  logic signed [15:0] i_steer_rate,
    input  logic [9:0]         i_step_count,
    output logic               o_valid,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic signed [15:0] o_end_heading,
    output logic signed [15:0] o_end_steer,
    output logic signed [15:0] o_end_hitch,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [24:0]        i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE, S_WMUL, S_WCOR,
        S_T_YAW, S_T_YAWD,
        S_TAN0, S_TAN1, S_TAN2, S_DIV, S_TAN3,
        S_PS0, S_PS1, S_PS2, S_X1, S_X2, S_Y1, S_Y2, S_Q1, S_Q2, S_ST,
        S_BT0, S_BT1, S_BT2, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
        S_FIN
    } t_state;

    t_state r_state;
    t_state r_ret;
    t_state r_tret;

    logic [15:0]        r_dt;
    logic [23:0]        r_il0;
    logic [23:0]        r_il1;
    logic signed [24:0] r_gain;
    logic signed [15:0] r_smin;
    logic signed [15:0] r_smax;
    logic signed [15:0] r_hmin;
    logic signed [15:0] r_hmax;

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [15:0]        r_yaw;
    logic signed [15:0] r_d0;
    logic signed [15:0] r_beta;
    logic signed [15:0] r_v;
    logic signed [15:0] r_rate;
    logic [9:0]         r_n;
    logic [9:0]         r_k;

    logic signed [15:0] r_c;
    logic signed [15:0] r_s;
    logic signed [15:0] r_cb;
    logic signed [15:0] r_sb;
    logic signed [20:0] r_td;
    logic signed [31:0] r_psi;
    logic signed [63:0] r_acc;
    logic signed [15:0] r_tang;

    logic               r_tneg;
    logic [28:0]        r_num;
    logic [15:0]        r_rem;
    logic [14:0]        r_den;
    logic [4:0]         r_dcnt;

    logic signed [63:0] r_ma;
    logic signed [31:0] r_mb;
    logic               r_mgo;
    logic [31:0]        r_turn;
    logic               r_cgo;

    logic               r_valid;
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;
    logic [15:0]        r_oyaw;
    logic signed [15:0] r_osteer;
    logic signed [15:0] r_ohitch;

    logic               mul_done;
    logic signed [63:0] prod;
    ttp_pkg::t_trig     trig;

    logic signed [31:0] psi_n;
    logic signed [31:0] x_n;
    logic signed [31:0] y_n;
    logic signed [31:0] q_n;
    logic [15:0]        dyaw;
    logic signed [15:0] d0_n;
    logic signed [15:0] beta_n;
    logic signed [63:0] d0_sum;
    logic signed [63:0] beta_sum;
    logic [15:0]        rem_sh;
    logic               qbit;
    logic [15:0]        sin_abs;
    logic [15:0]        cos_abs;
    logic signed [20:0] tq;
    logic [9:0]         n_clip;

    function automatic logic signed [63:0] sx16(input logic signed [15:0] v);
        return $signed({{48{v[15]}}, v});
    endfunction

    function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
        return $signed({{32{v[31]}}, v});
    endfunction

    function automatic logic signed [31:0] b16(input logic signed [15:0] v);
        return $signed({{16{v[15]}}, v});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [63:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
        logic signed [15:0] res;
        if (v < sx16(lo)) begin
            res = lo;
        end else if (v > sx16(hi)) begin
            res = hi;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    ttp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mgo),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    ttp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_cgo),
        .i_turn  (r_turn),
        .o_trig  (trig)
    );

    always_comb begin
        psi_n    = sat32(prod >>> 22);
        x_n      = sat32(sx32(r_x) + ((prod + 64'sd2097152) >>> 22));
        y_n      = sat32(sx32(r_y) + ((prod + 64'sd2097152) >>> 22));
        q_n      = 32'((prod + 64'sd32768) >>> 16);
        dyaw     = 16'((prod + 64'sd2147483648) >>> 32);
        d0_sum   = sx16(r_d0) + ((prod + 64'sd32768) >>> 16);
        beta_sum = sx16(r_beta) + ((prod + 64'sd131072) >>> 18);
        if (ttp_pkg::STEER_CLAMP) begin
            d0_n = clamp16(d0_sum, r_smin, r_smax);
        end else begin
            d0_n = clamp16(d0_sum, -16'sd32768, 16'sd32767);
        end
        beta_n  = clamp16(beta_sum, r_hmin, r_hmax);
        rem_sh  = {r_rem[14:0], r_num[28]};
        qbit    = (rem_sh >= {1'b0, r_den});
        sin_abs = trig.sin_q[15] ? 16'(-trig.sin_q) : trig.sin_q;
        cos_abs = trig.cos_q[15] ? 16'(-trig.cos_q) : trig.cos_q;
        tq      = (r_num > 29'd1048575) ? ttp_pkg::TAN_LIM : $signed({1'b0, r_num[19:0]});
        if ({22'd0, i_step_count} > ttp_pkg::MAX_STEPS) begin
            n_clip = 10'(ttp_pkg::MAX_STEPS);
        end else begin
            n_clip = i_step_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_tret  <= S_IDLE;
            r_mgo   <= 1'b0;
            r_cgo   <= 1'b0;
            r_valid <= 1'b0;
            r_dt    <= ttp_pkg::RST_STEP_SIZE;
            r_il0   <= ttp_pkg::RST_INV_WB;
            r_il1   <= ttp_pkg::RST_INV_TL;
            r_gain  <= ttp_pkg::RST_HITCH_GAIN;
            r_smin  <= ttp_pkg::RST_STEER_MIN;
            r_smax  <= ttp_pkg::RST_STEER_MAX;
            r_hmin  <= ttp_pkg::RST_HITCH_MIN;
            r_hmax  <= ttp_pkg::RST_HITCH_MAX;
        end else begin
            r_mgo   <= 1'b0;
            r_cgo   <= 1'b0;
            r_valid <= 1'b0;

            if (i_cfg_valid) begin
                case (ttp_pkg::t_reg_idx'(i_cfg_index))
                    ttp_pkg::REG_STEP_SIZE:  r_dt   <= i_cfg_data[15:0];
                    ttp_pkg::REG_INV_WB:     r_il0  <= i_cfg_data[23:0];
                    ttp_pkg::REG_INV_TL:     r_il1  <= i_cfg_data[23:0];
                    ttp_pkg::REG_HITCH_GAIN: r_gain <= $signed(i_cfg_data);
                    ttp_pkg::REG_STEER_MIN:  r_smin <= $signed(i_cfg_data[15:0]);
                    ttp_pkg::REG_STEER_MAX:  r_smax <= $signed(i_cfg_data[15:0]);
                    ttp_pkg::REG_HITCH_MIN:  r_hmin <= $signed(i_cfg_data[15:0]);
                    ttp_pkg::REG_HITCH_MAX:  r_hmax <= $signed(i_cfg_data[15:0]);
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_x    <= i_start_x;
                        r_y    <= i_start_y;
                        r_yaw  <= i_start_heading;
                        r_d0   <= i_start_steer;
                        r_beta <= i_start_hitch;
                        r_v    <= i_speed;
                        r_rate <= i_steer_rate;
                        r_n    <= n_clip;
                        r_k    <= 10'd0;
                        r_state <= (n_clip == 10'd0) ? S_FIN : S_T_YAW;
                    end
                end
                S_WMUL: begin
                    if (mul_done) begin
                        r_state <= r_ret;
                    end
                end
                S_WCOR: begin
                    if (trig.done) begin
                        r_state <= r_ret;
                    end
                end
                S_T_YAW: begin
                    r_turn  <= {r_yaw, 16'd0};
                    r_cgo   <= 1'b1;
                    r_ret   <= S_T_YAWD;
                    r_state <= S_WCOR;
                end
                S_T_YAWD: begin
                    r_c     <= trig.cos_q;
                    r_s     <= trig.sin_q;
                    r_tang  <= r_d0;
                    r_tret  <= S_PS0;
                    r_state <= S_TAN0;
                end
                // tan subroutine on r_tang, returns to r_tret with r_td
                S_TAN0: begin
                    r_ma    <= sx16(r_tang);
                    r_mb    <= ttp_pkg::RAD_TO_TURN;
                    r_mgo   <= 1'b1;
                    r_ret   <= S_TAN1;
                    r_state <= S_WMUL;
                end
                S_TAN1: begin
                    r_turn  <= prod[45:14];
                    r_cgo   <= 1'b1;
                    r_ret   <= S_TAN2;
                    r_state <= S_WCOR;
                end
                S_TAN2: begin
                    if (trig.cos_q == 16'sd0) begin
                        r_td    <= trig.sin_q[15] ? -ttp_pkg::TAN_LIM : ttp_pkg::TAN_LIM;
                        r_state <= r_tret;
                    end else begin
                        r_num   <= {sin_abs[14:0], 14'd0};
                        r_den   <= cos_abs[14:0];
                        r_rem   <= 16'd0;
                        r_dcnt  <= 5'd0;
                        r_tneg  <= trig.sin_q[15] ^ trig.cos_q[15];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= qbit ? (rem_sh - {1'b0, r_den}) : rem_sh;
                    r_num  <= {r_num[27:0], qbit};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == ttp_pkg::DIV_LAST) begin
                        r_state <= S_TAN3;
                    end
                end
                S_TAN3: begin
                    r_td    <= r_tneg ? -tq : tq;
                    r_state <= r_tret;
                end
                S_PS0: begin
                    r_ma    <= $signed({40'd0, r_il0});
                    r_mb    <= b16(r_v);
                    r_mgo   <= 1'b1;
                    r_ret   <= S_PS1;
                    r_state <= S_WMUL;
                end
                S_PS1: begin
                    r_ma    <= prod;
                    r_mb    <= $signed({{11{r_td[20]}}, r_td});
                    r_mgo   <= 1'b1;
                    r_ret   <= S_PS2;
                    r_state <= S_WMUL;
                end
                S_PS2: begin
                    r_psi   <= psi_n;
                    r_ma    <= sx16(r_c);
                    r_mb    <= b16(r_v);
                    r_mgo   <= 1'b1;
                    r_ret   <= S_X1;
                    r_state <= S_WMUL;
                end
                S_X1: begin
                    r_ma    <= prod;
                    r_mb    <= $signed({16'd0, r_dt});
                    r_mgo   <= 1'b1;
                    r_ret   <= S_X2;
                    r_state <= S_WMUL;
                end
                S_X2: begin
                    r_x     <= x_n;
                    r_ma    <= sx16(r_s);
                    r_mb    <= b16(r_v);
                    r_mgo   <= 1'b1;
                    r_ret   <= S_Y1;
                    r_state <= S_WMUL;
                end
                S_Y1: begin
                    r_ma    <= prod;
                    r_mb    <= $signed({16'd0, r_dt});
                    r_mgo   <= 1'b1;
                    r_ret   <= S_Y2;
                    r_state <= S_WMUL;
                end
                S_Y2: begin
                    r_y     <= y_n;
                    r_ma    <= sx32(r_psi);
                    r_mb    <= $signed({16'd0, r_dt});
                    r_mgo   <= 1'b1;
                    r_ret   <= S_Q1;
                    r_state <= S_WMUL;
                end
                S_Q1: begin
                    r_ma    <= sx32(ttp_pkg::RAD_TO_TURN);
                    r_mb    <= q_n;
                    r_mgo   <= 1'b1;
                    r_ret   <= S_Q2;
                    r_state <= S_WMUL;
                end
                S_Q2: begin
                    r_yaw   <= r_yaw + dyaw;
                    r_ma    <= sx16(r_rate);
                    r_mb    <= $signed({16'd0, r_dt});
                    r_mgo   <= 1'b1;
                    r_ret   <= S_ST;
                    r_state <= S_WMUL;
                end
                S_ST: begin
                    r_d0    <= d0_n;
                    r_tang  <= d0_n;
                    r_tret  <= S_BT0;
                    r_state <= S_TAN0;
                end
                S_BT0: begin
                    r_ma    <= sx16(r_beta);
                    r_mb    <= ttp_pkg::RAD_TO_TURN;
                    r_mgo   <= 1'b1;
                    r_ret   <= S_BT1;
                    r_state <= S_WMUL;
                end
                S_BT1: begin
                    r_turn  <= prod[45:14];
                    r_cgo   <= 1'b1;
                    r_ret   <= S_BT2;
                    r_state <= S_WCOR;
                end
                S_BT2: begin
                    r_cb    <= trig.cos_q;
                    r_sb    <= trig.sin_q;
                    r_ma    <= $signed({{39{r_gain[24]}}, r_gain});
                    r_mb    <= b16(r_v);
                    r_mgo   <= 1'b1;
                    r_ret   <= S_H1;
                    r_state <= S_WMUL;
                end
                S_H1: begin
                    r_ma    <= prod >>> 8;
                    r_mb    <= $signed({{11{r_td[20]}}, r_td});
                    r_mgo   <= 1'b1;
                    r_ret   <= S_H2;
                    r_state <= S_WMUL;
                end
                S_H2: begin
                    r_ma    <= prod >>> 14;
                    r_mb    <= b16(r_cb);
                    r_mgo   <= 1'b1;
                    r_ret   <= S_H3;
                    r_state <= S_WMUL;
                end
                S_H3: begin
                    r_acc   <= (prod >>> 14) - sx32(r_psi);
                    r_ma    <= $signed({40'd0, r_il1});
                    r_mb    <= b16(r_v);
                    r_mgo   <= 1'b1;
                    r_ret   <= S_H4;
                    r_state <= S_WMUL;
                end
                S_H4: begin
                    r_ma    <= prod;
                    r_mb    <= b16(r_sb);
                    r_mgo   <= 1'b1;
                    r_ret   <= S_H5;
                    r_state <= S_WMUL;
                end
                S_H5: begin
                    r_ma    <= r_acc + (prod >>> 22);
                    r_mb    <= $signed({16'd0, r_dt});
                    r_mgo   <= 1'b1;
                    r_ret   <= S_H6;
                    r_state <= S_WMUL;
                end
                S_H6: begin
                    r_beta <= beta_n;
                    if (r_k == r_n - 10'd1) begin
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_k + 10'd1;
                        r_state <= S_T_YAW;
                    end
                end
                S_FIN: begin
                    r_ox     <= r_x;
                    r_oy     <= r_y;
                    r_oyaw   <= r_yaw;
                    r_osteer <= clamp16(sx16(r_d0), r_smin, r_smax);
                    r_ohitch <= clamp16(sx16(r_beta), r_hmin, r_hmax);
                    r_valid  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_end_x       = r_ox;
    assign o_end_y       = r_oy;
    assign o_end_heading = r_oyaw;
    assign o_end_steer   = r_osteer;
    assign o_end_hitch   = r_ohitch;
    assign o_cfg_ready   = 1'b1;

endmodule

// ===== rtl/ttp_check.sv =====
`timescale 1ns / 1ps
`include "tractor_trailer_propagate_macros.svh"
module ttp_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    `TTP_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "transfer did not raise busy")
    `TTP_ASSERT_NEXT(a_strobe_once, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held")
    `TTP_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")

endmodule

bind tractor_trailer_propagate ttp_check u_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic signed [15:0] steer;
        logic signed [15:0] hitch;
        logic signed [15:0] speed;
        logic signed [15:0] rate;
        logic [9:0]         count;
    } t_pose_cmd;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic signed [15:0] steer;
        logic signed [15:0] hitch;
    } t_pose;

    localparam longint ANG_SCALE = 64'sd683565276;
    localparam longint GAIN0     = 64'sd652032874;
    localparam longint TAN_MAX   = 64'sd1048575;
    localparam longint I32_MIN   = -64'sd2147483648;
    localparam longint I32_MAX   = 64'sd2147483647;
    localparam longint ARCTAB [16] = '{536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861};

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_start_x;
    logic signed [31:0] i_start_y;
    logic signed [15:0] i_start_heading;
    logic signed [15:0] i_start_steer;
    logic signed [15:0] i_start_hitch;
    logic signed [15:0] i_speed;
    logic signed [15:0] i_steer_rate;
    logic [9:0]         i_step_count;
    logic               o_valid;
    logic signed [31:0] o_end_x;
    logic signed [31:0] o_end_y;
    logic signed [15:0] o_end_heading;
    logic signed [15:0] o_end_steer;
    logic signed [15:0] o_end_hitch;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [24:0]        i_cfg_data;

    logic [24:0] cfg_regs [8];
    t_pose       pending_poses [$];
    int          error_count;
    int          sender_idle_pct;

    tractor_trailer_propagate DUT (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint to_q14(longint v);
        return clip((v + 32768) >>> 16, -16384, 16384);
    endfunction

    function automatic void cordic_sincos(input logic [31:0] turn, output longint c,
                                          output longint s);
        longint a, xc, yc, dx, dy;
        bit     flip;
        a = longint'(turn);
        flip = 1'b0;
        xc = GAIN0;
        yc = 0;
        if (a >= (64'sd1 <<< 31)) a -= (64'sd1 <<< 32);
        if (a > (64'sd1 <<< 30)) begin
            a -= (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (a < -(64'sd1 <<< 30)) begin
            a += (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = yc >>> i;
            dy = xc >>> i;
            if (a >= 0) begin
                xc -= dx;
                yc += dy;
                a -= ARCTAB[i];
            end else begin
                xc += dx;
                yc -= dy;
                a += ARCTAB[i];
            end
        end
        c = to_q14(xc);
        s = to_q14(yc);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic logic [31:0] rad_turn(longint r);
        longint t;
        t = (r * ANG_SCALE) >>> 14;
        return t[31:0];
    endfunction

    function automatic longint tan_q14(longint r);
        longint c, s;
        cordic_sincos(rad_turn(r), c, s);
        if (c == 0) return (s >= 0) ? TAN_MAX : -TAN_MAX;
        return clip((s * 16384) / c, -TAN_MAX, TAN_MAX);
    endfunction

    function automatic t_pose propagate_pose(t_pose_cmd cmd);
        t_pose       res;
        longint      px, py, d0, beta, v, rate, dt, il0, il1, gain;
        longint      smin, smax, hmin, hmax, c, s, cb, sb, td, psidot, q, dyaw, g, bd;
        logic [15:0] yaw;
        int          n;
        px = cmd.x;
        py = cmd.y;
        yaw = cmd.heading;
        d0 = cmd.steer;
        beta = cmd.hitch;
        v = cmd.speed;
        rate = cmd.rate;
        n = (cmd.count > ttp_pkg::MAX_STEPS) ? int'(ttp_pkg::MAX_STEPS) : int'(cmd.count);
        dt = longint'(cfg_regs[ttp_pkg::REG_STEP_SIZE][15:0]);
        il0 = longint'(cfg_regs[ttp_pkg::REG_INV_WB][23:0]);
        il1 = longint'(cfg_regs[ttp_pkg::REG_INV_TL][23:0]);
        gain = longint'($signed(cfg_regs[ttp_pkg::REG_HITCH_GAIN][24:0]));
        smin = longint'($signed(cfg_regs[ttp_pkg::REG_STEER_MIN][15:0]));
        smax = longint'($signed(cfg_regs[ttp_pkg::REG_STEER_MAX][15:0]));
        hmin = longint'($signed(cfg_regs[ttp_pkg::REG_HITCH_MIN][15:0]));
        hmax = longint'($signed(cfg_regs[ttp_pkg::REG_HITCH_MAX][15:0]));
        for (int k = 0; k < n; k++) begin
            cordic_sincos({yaw, 16'd0}, c, s);
            td = tan_q14(d0);
            psidot = clip((v * il0 * td) >>> 22, I32_MIN, I32_MAX);
            px = clip(px + ((v * c * dt + (64'sd1 <<< 21)) >>> 22), I32_MIN, I32_MAX);
            py = clip(py + ((v * s * dt + (64'sd1 <<< 21)) >>> 22), I32_MIN, I32_MAX);
            q = (psidot * dt + 32768) >>> 16;
            dyaw = (q * ANG_SCALE + (64'sd1 <<< 31)) >>> 32;
            yaw = yaw + dyaw[15:0];
            d0 += (rate * dt + 32768) >>> 16;
            if (ttp_pkg::STEER_CLAMP) d0 = clip(d0, smin, smax);
            else d0 = clip(d0, -32768, 32767);
            td = tan_q14(d0);
            cordic_sincos(rad_turn(beta), cb, sb);
            g = (v * gain) >>> 8;
            bd = -psidot + ((v * il1 * sb) >>> 22) + ((((g * td) >>> 14) * cb) >>> 14);
            beta = clip(beta + ((bd * dt + (64'sd1 <<< 17)) >>> 18), hmin, hmax);
        end
        res.x = px[31:0];
        res.y = py[31:0];
        res.heading = yaw;
        res.steer = 16'(clip(d0, smin, smax));
        res.hitch = 16'(clip(beta, hmin, hmax));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && o_valid) begin
            if (pending_poses.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_poses.pop_front();
                if (o_end_x !== want.x) report_mismatch("end_x", o_end_x, want.x);
                if (o_end_y !== want.y) report_mismatch("end_y", o_end_y, want.y);
                if (o_end_heading !== want.heading)
                    report_mismatch("end_heading", o_end_heading, want.heading);
                if (o_end_steer !== want.steer)
                    report_mismatch("end_steer", o_end_steer, want.steer);
                if (o_end_hitch !== want.hitch)
                    report_mismatch("end_hitch", o_end_hitch, want.hitch);
            end
        end
    end

    task automatic send_pose(t_pose_cmd cmd);
        if ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start = 1'b1;
        i_start_x = cmd.x;
        i_start_y = cmd.y;
        i_start_heading = cmd.heading;
        i_start_steer = cmd.steer;
        i_start_hitch = cmd.hitch;
        i_speed = cmd.speed;
        i_steer_rate = cmd.rate;
        i_step_count = cmd.count;
        do @(posedge i_clk); while (busy);
        pending_poses.push_back(propagate_pose(cmd));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_poses.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(ttp_pkg::t_reg_idx idx, logic [24:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_regs[idx] = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_pose_cmd rand_cmd();
        t_pose_cmd cmd;
        cmd.x = $urandom;
        cmd.y = $urandom;
        cmd.heading = 16'($urandom);
        cmd.steer = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(20000) - 10000);
        cmd.hitch = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(50000) - 25000);
        cmd.speed = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(8000) - 4000);
        cmd.rate = 16'($urandom);
        if ($urandom_range(49) == 0) cmd.count = 10'($urandom_range(60));
        else cmd.count = 10'($urandom_range(6));
        return cmd;
    endfunction

    function automatic t_pose_cmd make_cmd(longint px, longint py, longint hd, longint st,
                                           longint ht, longint sp, longint rt, int n);
        t_pose_cmd cmd;
        cmd.x = 32'(px);
        cmd.y = 32'(py);
        cmd.heading = 16'(hd);
        cmd.steer = 16'(st);
        cmd.hitch = 16'(ht);
        cmd.speed = 16'(sp);
        cmd.rate = 16'(rt);
        cmd.count = 10'(n);
        return cmd;
    endfunction

    task automatic test_directed();
        send_pose(make_cmd(0, 0, 0, 0, 0, 256, 0, 1));
        send_pose(make_cmd(I32_MAX, I32_MIN, 32767, 32767, 32767, 32767, 32767, 0));
        send_pose(make_cmd(I32_MIN, I32_MAX, -32768, -32768, -32768, -32768, -32768, 0));
        send_pose(make_cmd(I32_MAX - 5, I32_MAX - 5, 0, 0, 0, 32767, 0, 3));
        send_pose(make_cmd(I32_MIN + 5, I32_MIN + 5, -32768, 0, 0, 32767, 0, 3));
        send_pose(make_cmd(12345, -6789, 16384, 25736, -20000, -32768, 32767, 4));
        send_pose(make_cmd(-1, 1, -16384, -25736, 32767, 1000, -32768, 5));
        wait_idle();
        send_pose(make_cmd(100, 200, 8000, 3000, 1000, 2000, -500, 1023));
        send_pose(make_cmd(0, 0, 0, 0, 0, 0, 0, 512));
    endtask

    task automatic test_config_extremes();
        wait_idle();
        write_reg(ttp_pkg::REG_STEP_SIZE, 25'd0);
        write_reg(ttp_pkg::REG_INV_WB, 25'hFFFFFF);
        write_reg(ttp_pkg::REG_INV_TL, 25'hFFFFFF);
        write_reg(ttp_pkg::REG_HITCH_GAIN, 25'h1000000);
        write_reg(ttp_pkg::REG_STEER_MIN, 25'h0008000);
        write_reg(ttp_pkg::REG_STEER_MAX, 25'h0007FFF);
        write_reg(ttp_pkg::REG_HITCH_MIN, 25'h0008000);
        write_reg(ttp_pkg::REG_HITCH_MAX, 25'h0007FFF);
        send_pose(make_cmd(55, 66, 1234, 32767, -32768, 32767, 32767, 4));
        wait_idle();
        write_reg(ttp_pkg::REG_STEP_SIZE, 25'hFFFF);
        write_reg(ttp_pkg::REG_HITCH_GAIN, 25'h0FFFFFF);
        write_reg(ttp_pkg::REG_INV_WB, 25'd0);
        write_reg(ttp_pkg::REG_INV_TL, 25'd0);
        send_pose(make_cmd(0, 0, 0, 25736, 0, -32768, -32768, 3));
        send_pose(make_cmd(-7, 7, 32767, 0, 100, 32767, 32767, 3));
        wait_idle();
        // lower limit above upper limit
        write_reg(ttp_pkg::REG_INV_WB, 25'd21845);
        write_reg(ttp_pkg::REG_INV_TL, 25'd13107);
        write_reg(ttp_pkg::REG_STEER_MIN, 25'd4000);
        write_reg(ttp_pkg::REG_STEER_MAX, 25'h1FFF060);
        write_reg(ttp_pkg::REG_HITCH_MIN, 25'd2000);
        write_reg(ttp_pkg::REG_HITCH_MAX, 25'h1FFF830);
        send_pose(make_cmd(0, 0, 0, 0, 0, 512, 300, 2));
        send_pose(make_cmd(0, 0, 0, 6000, 3000, 512, -300, 0));
        send_pose(make_cmd(0, 0, 0, -6000, -3000, -512, 900, 2));
    endtask

    task automatic test_random_phase(int items, int idle_pct);
        wait_idle();
        write_reg(ttp_pkg::REG_STEP_SIZE, 25'($urandom_range(1, 4000)));
        write_reg(ttp_pkg::REG_INV_WB, 25'($urandom_range(1, 200000)));
        write_reg(ttp_pkg::REG_INV_TL, 25'($urandom_range(1, 200000)));
        write_reg(ttp_pkg::REG_HITCH_GAIN, 25'({$urandom} % 40000 - 20000));
        write_reg(ttp_pkg::REG_STEER_MIN, 25'(-$urandom_range(1, 20000)));
        write_reg(ttp_pkg::REG_STEER_MAX, 25'($urandom_range(1, 20000)));
        write_reg(ttp_pkg::REG_HITCH_MIN, 25'(-$urandom_range(1, 30000)));
        write_reg(ttp_pkg::REG_HITCH_MAX, 25'($urandom_range(1, 30000)));
        sender_idle_pct = idle_pct;
        for (int i = 0; i < items; i++) begin
            send_pose(rand_cmd());
            if (i == items / 2) wait_idle();
        end
    endtask

    initial begin
        error_count = 0;
        sender_idle_pct = 38;
        start = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_start_x = '0;
        i_start_y = '0;
        i_start_heading = '0;
        i_start_steer = '0;
        i_start_hitch = '0;
        i_speed = '0;
        i_steer_rate = '0;
        i_step_count = '0;
        cfg_regs[ttp_pkg::REG_STEP_SIZE] = 25'(ttp_pkg::RST_STEP_SIZE);
        cfg_regs[ttp_pkg::REG_INV_WB] = 25'(ttp_pkg::RST_INV_WB);
        cfg_regs[ttp_pkg::REG_INV_TL] = 25'(ttp_pkg::RST_INV_TL);
        cfg_regs[ttp_pkg::REG_HITCH_GAIN] = ttp_pkg::RST_HITCH_GAIN;
        cfg_regs[ttp_pkg::REG_STEER_MIN] = 25'(ttp_pkg::RST_STEER_MIN);
        cfg_regs[ttp_pkg::REG_STEER_MAX] = 25'(ttp_pkg::RST_STEER_MAX);
        cfg_regs[ttp_pkg::REG_HITCH_MIN] = 25'(ttp_pkg::RST_HITCH_MIN);
        cfg_regs[ttp_pkg::REG_HITCH_MAX] = 25'(ttp_pkg::RST_HITCH_MAX);
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random_phase(190, 38);
        test_random_phase(190, 74);
        test_random_phase(190, 0);
        wait_idle();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
